// ===== rtl/core/ppp_pkg.sv =====
// ppp_pkg: widths, register indexes, reset values and stage types
// for the perspective point projection pipeline; no dependencies
package ppp_pkg;

   localparam int COORD_W  = 16;
   localparam int PROD_W   = 32;
   localparam int XO_W     = 33;
   localparam int WIDE_W   = 48;
   localparam int SUM_W    = 50;
   localparam int OBS_W    = 36;
   localparam int MUL_W    = 53;
   localparam int NUM_W    = 57;
   localparam int MAG_W    = 56;
   localparam int DEN_W    = 41;
   localparam int QB       = 18;
   localparam int REM_W    = DEN_W + QB;
   localparam int HALF_W   = 11;
   localparam int FRAC_SH  = 14;
   localparam int DIST_SH  = 28;
   localparam int N_STAGES = 6 + QB + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int SCREEN_W   = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SIN_THETA       = 3'd0,
      REG_COS_THETA       = 3'd1,
      REG_SIN_PHI         = 3'd2,
      REG_COS_PHI         = 3'd3,
      REG_VIEWER_DISTANCE = 3'd4,
      REG_SCREEN_DISTANCE = 3'd5,
      REG_SCREEN_WIDTH    = 3'd6,
      REG_SCREEN_HEIGHT   = 3'd7
   } csr_index_type;

   localparam logic signed [COORD_W-1:0] RST_SIN_THETA = 16'sd0;
   localparam logic signed [COORD_W-1:0] RST_COS_THETA = 16'sd16384;
   localparam logic signed [COORD_W-1:0] RST_SIN_PHI   = 16'sd0;
   localparam logic signed [COORD_W-1:0] RST_COS_PHI   = 16'sd16384;
   localparam logic [COORD_W-1:0]  RST_VIEWER_DIST = 16'd2560;
   localparam logic [COORD_W-1:0]  RST_SCREEN_DIST = 16'd256;
   localparam logic [SCREEN_W-1:0] RST_SCREEN_W    = 12'd640;
   localparam logic [SCREEN_W-1:0] RST_SCREEN_H    = 12'd480;

   typedef struct packed {
      logic [REM_W-1:0] rem_x;
      logic [REM_W-1:0] rem_y;
      logic [QB-1:0]    quo_x;
      logic [QB-1:0]    quo_y;
      logic [DEN_W-1:0] den;
      logic             neg_x;
      logic             neg_y;
      logic             ovf_x;
      logic             ovf_y;
      logic             behind;
      logic             pen;
   } div_stage_type;

endpackage

// ===== rtl/core/perspective_point_projection.sv =====
// perspective_point_projection: rotate, project and round one point per beat
// depends on ppp_pkg
//
//  channel | ports                                   | direction
//  req     | req_valid/ready, point_x/y/z, mode      | in
//  rsp     | rsp_valid/ready, screen_x/y, pen, behind| out
//  csr     | csr_valid/ready, csr_index, csr_data    | in
//
// one beat per cycle while rsp is not stalled: six arithmetic stages, 18 stages
// of restoring division (one quotient bit each), one output register
// synchronous reset clears valid bits and loads register defaults
// a stalled rsp beat holds the whole pipeline; req_ready falls with it
module perspective_point_projection (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [ppp_pkg::COORD_W-1:0]   req_point_x,
   input  logic signed [ppp_pkg::COORD_W-1:0]   req_point_y,
   input  logic signed [ppp_pkg::COORD_W-1:0]   req_point_z,
   input  logic                                 req_mode,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [ppp_pkg::COORD_W-1:0]   rsp_screen_x,
   output logic signed [ppp_pkg::COORD_W-1:0]   rsp_screen_y,
   output logic                                 rsp_pen_down,
   output logic                                 rsp_behind_viewer,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ppp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ppp_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int CW = ppp_pkg::COORD_W;
   localparam int PW = ppp_pkg::PROD_W;
   localparam int WW = ppp_pkg::WIDE_W;
   localparam int SW = ppp_pkg::SUM_W;
   localparam int OW = ppp_pkg::OBS_W;
   localparam int MW = ppp_pkg::MUL_W;
   localparam int NW = ppp_pkg::NUM_W;
   localparam int AW = ppp_pkg::MAG_W;
   localparam int DW = ppp_pkg::DEN_W;
   localparam int RW = ppp_pkg::REM_W;
   localparam int QB = ppp_pkg::QB;
   localparam int NS = ppp_pkg::N_STAGES;

   // configuration
   logic signed [CW-1:0] sin_theta_ff, cos_theta_ff, sin_phi_ff, cos_phi_ff;
   logic [CW-1:0] viewer_dist_ff, screen_dist_ff;
   logic [ppp_pkg::SCREEN_W-1:0] screen_w_ff, screen_h_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sin_theta_ff   <= ppp_pkg::RST_SIN_THETA;
         cos_theta_ff   <= ppp_pkg::RST_COS_THETA;
         sin_phi_ff     <= ppp_pkg::RST_SIN_PHI;
         cos_phi_ff     <= ppp_pkg::RST_COS_PHI;
         viewer_dist_ff <= ppp_pkg::RST_VIEWER_DIST;
         screen_dist_ff <= ppp_pkg::RST_SCREEN_DIST;
         screen_w_ff    <= ppp_pkg::RST_SCREEN_W;
         screen_h_ff    <= ppp_pkg::RST_SCREEN_H;
      end else if (csr_valid) begin
         unique case (ppp_pkg::csr_index_type'(csr_index))
            ppp_pkg::REG_SIN_THETA:       sin_theta_ff   <= csr_data;
            ppp_pkg::REG_COS_THETA:       cos_theta_ff   <= csr_data;
            ppp_pkg::REG_SIN_PHI:         sin_phi_ff     <= csr_data;
            ppp_pkg::REG_COS_PHI:         cos_phi_ff     <= csr_data;
            ppp_pkg::REG_VIEWER_DISTANCE: viewer_dist_ff <= csr_data;
            ppp_pkg::REG_SCREEN_DISTANCE: screen_dist_ff <= csr_data;
            ppp_pkg::REG_SCREEN_WIDTH:
               screen_w_ff <= csr_data[ppp_pkg::SCREEN_W-1:0];
            ppp_pkg::REG_SCREEN_HEIGHT:
               screen_h_ff <= csr_data[ppp_pkg::SCREEN_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic [NS-1:0] valid_ff;
   logic          advance;

   assign advance   = !valid_ff[NS-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NS-2:0], req_valid};
      end
   end

   // stage 1: angle products and single products
   logic signed [CW-1:0] s1_x_ff, s1_y_ff;
   logic signed [PW-1:0] s1_xst_ff, s1_yct_ff, s1_zcp_ff, s1_zsp_ff;
   logic signed [PW-1:0] s1_ctsp_ff, s1_stsp_ff, s1_ctcp_ff, s1_stcp_ff;
   logic                 s1_pen_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x_ff    <= req_point_x;
         s1_y_ff    <= req_point_y;
         s1_xst_ff  <= req_point_x * sin_theta_ff;
         s1_yct_ff  <= req_point_y * cos_theta_ff;
         s1_zcp_ff  <= req_point_z * cos_phi_ff;
         s1_zsp_ff  <= req_point_z * sin_phi_ff;
         s1_ctsp_ff <= cos_theta_ff * sin_phi_ff;
         s1_stsp_ff <= sin_theta_ff * sin_phi_ff;
         s1_ctcp_ff <= cos_theta_ff * cos_phi_ff;
         s1_stcp_ff <= sin_theta_ff * cos_phi_ff;
         s1_pen_ff  <= req_mode;
      end
   end

   // stage 2: horizontal offset and point times angle products
   logic signed [ppp_pkg::XO_W-1:0] s2_xo_ff;
   logic signed [PW-1:0] s2_zcp_ff, s2_zsp_ff;
   logic signed [WW-1:0] s2_xctsp_ff, s2_ystsp_ff, s2_xctcp_ff, s2_ystcp_ff;
   logic                 s2_pen_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_xo_ff    <= ppp_pkg::XO_W'(s1_yct_ff) - ppp_pkg::XO_W'(s1_xst_ff);
         s2_zcp_ff   <= s1_zcp_ff;
         s2_zsp_ff   <= s1_zsp_ff;
         s2_xctsp_ff <= s1_x_ff * s1_ctsp_ff;
         s2_ystsp_ff <= s1_y_ff * s1_stsp_ff;
         s2_xctcp_ff <= s1_x_ff * s1_ctcp_ff;
         s2_ystcp_ff <= s1_y_ff * s1_stcp_ff;
         s2_pen_ff   <= s1_pen_ff;
      end
   end

   // stage 3: vertical offset and depth, floored to Q22.14
   logic signed [SW-1:0] yo36, zo36, yo_sh, zo_sh, rol_term;
   logic signed [ppp_pkg::XO_W-1:0] s3_xo_ff;
   logic signed [OW-1:0] s3_yo_ff, s3_zo_ff;
   logic                 s3_pen_ff;

   always_comb begin
      rol_term = $signed(SW'(viewer_dist_ff)) <<< ppp_pkg::DIST_SH;
      yo36 = (SW'(s2_zcp_ff) <<< ppp_pkg::FRAC_SH) - SW'(s2_xctsp_ff)
             - SW'(s2_ystsp_ff);
      zo36 = rol_term - SW'(s2_xctcp_ff) - SW'(s2_ystcp_ff)
             - (SW'(s2_zsp_ff) <<< ppp_pkg::FRAC_SH);
      yo_sh = yo36 >>> ppp_pkg::FRAC_SH;
      zo_sh = zo36 >>> ppp_pkg::FRAC_SH;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_xo_ff  <= s2_xo_ff;
         s3_yo_ff  <= yo_sh[OW-1:0];
         s3_zo_ff  <= zo_sh[OW-1:0];
         s3_pen_ff <= s2_pen_ff;
      end
   end

   // stage 4: scale by screen distance, flag depth <= 0 as behind the viewer
   logic signed [CW:0]   de_s;
   logic signed [OW-1:0] xo_ext;
   logic signed [MW-1:0] s4_mx_ff, s4_my_ff;
   logic signed [OW-1:0] s4_zo_ff;
   logic                 s4_behind_ff, s4_pen_ff;

   assign de_s   = $signed({1'b0, screen_dist_ff});
   assign xo_ext = OW'(s3_xo_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_mx_ff     <= de_s * xo_ext;
         s4_my_ff     <= de_s * s3_yo_ff;
         s4_zo_ff     <= s3_zo_ff;
         s4_behind_ff <= s3_zo_ff[OW-1] || (s3_zo_ff == '0);
         s4_pen_ff    <= s3_pen_ff;
      end
   end

   // stage 5: numerators with rounding half, magnitudes for floor division
   logic signed [NW-1:0] num_x, num_y, zo_term;
   logic signed [AW-1:0] s5_mag_x_ff, s5_mag_y_ff;
   logic [DW-1:0]        s5_den_ff;
   logic                 s5_neg_x_ff, s5_neg_y_ff, s5_behind_ff, s5_pen_ff;

   always_comb begin
      zo_term = NW'(s4_zo_ff) <<< 5;
      num_x = (NW'(s4_mx_ff) <<< 2) + NW'(s4_mx_ff) + zo_term;
      num_y = zo_term - (NW'(s4_my_ff) <<< 2) - NW'(s4_my_ff);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_neg_x_ff  <= num_x[NW-1];
         s5_neg_y_ff  <= num_y[NW-1];
         s5_mag_x_ff  <= num_x[NW-1] ? ~num_x[AW-1:0] : num_x[AW-1:0];
         s5_mag_y_ff  <= num_y[NW-1] ? ~num_y[AW-1:0] : num_y[AW-1:0];
         s5_den_ff    <= {s4_zo_ff[DW-7:0], 6'b0};
         s5_behind_ff <= s4_behind_ff;
         s5_pen_ff    <= s4_pen_ff;
      end
   end

   // stage 6 and divider: range check then one quotient bit per stage
   ppp_pkg::div_stage_type div_ff [QB+1];
   logic [RW-1:0] den_top;

   assign den_top = {s5_den_ff, {QB{1'b0}}};

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff[0].rem_x  <= RW'(s5_mag_x_ff);
         div_ff[0].rem_y  <= RW'(s5_mag_y_ff);
         div_ff[0].quo_x  <= '0;
         div_ff[0].quo_y  <= '0;
         div_ff[0].den    <= s5_den_ff;
         div_ff[0].neg_x  <= s5_neg_x_ff;
         div_ff[0].neg_y  <= s5_neg_y_ff;
         div_ff[0].ovf_x  <= RW'(s5_mag_x_ff) >= den_top;
         div_ff[0].ovf_y  <= RW'(s5_mag_y_ff) >= den_top;
         div_ff[0].behind <= s5_behind_ff;
         div_ff[0].pen    <= s5_pen_ff;
      end
   end

   for (genvar i = 1; i <= QB; i++) begin : g_div
      localparam int K = QB - i;
      logic [RW-1:0]          den_k;
      logic                   ge_x, ge_y;
      ppp_pkg::div_stage_type div_in;

      assign den_k = RW'(div_ff[i-1].den) << K;
      assign ge_x  = div_ff[i-1].rem_x >= den_k;
      assign ge_y  = div_ff[i-1].rem_y >= den_k;

      always_comb begin
         div_in          = div_ff[i-1];
         div_in.rem_x    = ge_x ? div_ff[i-1].rem_x - den_k : div_ff[i-1].rem_x;
         div_in.rem_y    = ge_y ? div_ff[i-1].rem_y - den_k : div_ff[i-1].rem_y;
         div_in.quo_x[K] = ge_x;
         div_in.quo_y[K] = ge_y;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_ff[i] <= div_in;
         end
      end
   end

   // output: centre offset, saturation
   localparam int FW = QB + 2;
   logic [QB-1:0]        u_x, u_y;
   logic signed [QB:0]   q_x, q_y;
   logic signed [FW-1:0] sum_x, sum_y, half_x, half_y;
   logic signed [CW-1:0] sat_x, sat_y;
   logic signed [CW-1:0] out_x_ff, out_y_ff;
   logic                 out_pen_ff, out_behind_ff;

   always_comb begin
      u_x    = div_ff[QB].ovf_x ? '1 : div_ff[QB].quo_x;
      u_y    = div_ff[QB].ovf_y ? '1 : div_ff[QB].quo_y;
      q_x    = div_ff[QB].neg_x ? ~$signed({1'b0, u_x}) : $signed({1'b0, u_x});
      q_y    = div_ff[QB].neg_y ? ~$signed({1'b0, u_y}) : $signed({1'b0, u_y});
      half_x = $signed(FW'(screen_w_ff[ppp_pkg::SCREEN_W-1:1]));
      half_y = $signed(FW'(screen_h_ff[ppp_pkg::SCREEN_W-1:1]));
      sum_x  = half_x + FW'(q_x);
      sum_y  = half_y + FW'(q_y);
      priority if (sum_x > FW'(32767))       sat_x = 16'sh7FFF;
      else if (sum_x < -FW'(32768))          sat_x = -16'sh8000;
      else                                   sat_x = sum_x[CW-1:0];
      priority if (sum_y > FW'(32767))       sat_y = 16'sh7FFF;
      else if (sum_y < -FW'(32768))          sat_y = -16'sh8000;
      else                                   sat_y = sum_y[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_x_ff      <= div_ff[QB].behind ? '0 : sat_x;
         out_y_ff      <= div_ff[QB].behind ? '0 : sat_y;
         out_pen_ff    <= div_ff[QB].pen;
         out_behind_ff <= div_ff[QB].behind;
      end
   end

   assign rsp_screen_x      = out_x_ff;
   assign rsp_screen_y      = out_y_ff;
   assign rsp_pen_down      = out_pen_ff;
   assign rsp_behind_viewer = out_behind_ff;

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking bench for perspective_point_projection
// depends on ppp_pkg and the rtl top; a directed table, then random points
// under several view settings, all checked against an in-bench projection
`timescale 1ns / 1ps

module tb_top;

   typedef struct packed {
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic               pen;
      logic               behind;
   } pixel_type;

   typedef struct {
      logic signed [15:0] x, y, z;
      logic               mode;
      bit                 typed;
      pixel_type          want;
   } point_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   logic signed [15:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic req_mode = 1'b0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic signed [15:0] rsp_screen_x, rsp_screen_y;
   logic rsp_pen_down, rsp_behind_viewer;
   logic csr_valid = 1'b0, csr_ready;
   logic [ppp_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ppp_pkg::CSR_DATA_W-1:0] csr_data = '0;

   logic [15:0] view_regs [8];
   pixel_type   pending_pixels [$];
   pixel_type   typed_pixels [$];
   bit          typed_flags [$];
   int          fails = 0;
   int          burst_left = 0;

   perspective_point_projection dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #(20 * 400000);
      $display("Mismatches found");
      $finish;
   end

   function automatic longint floor_quot(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
   endfunction

   function automatic longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic pixel_type project_point(logic signed [15:0] px, py, pz, logic m);
      longint x, y, z, st, ct, sp, cp, rol, de, hw, hh;
      longint xo, yo, zo, yo36, zo36, den, nx, ny;
      pixel_type r;
      x = px; y = py; z = pz;
      st = $signed(view_regs[ppp_pkg::REG_SIN_THETA]);
      ct = $signed(view_regs[ppp_pkg::REG_COS_THETA]);
      sp = $signed(view_regs[ppp_pkg::REG_SIN_PHI]);
      cp = $signed(view_regs[ppp_pkg::REG_COS_PHI]);
      rol = view_regs[ppp_pkg::REG_VIEWER_DISTANCE];
      de = view_regs[ppp_pkg::REG_SCREEN_DISTANCE];
      hw = view_regs[ppp_pkg::REG_SCREEN_WIDTH][11:1];
      hh = view_regs[ppp_pkg::REG_SCREEN_HEIGHT][11:1];
      xo = -x * st + y * ct;
      yo36 = -x * (ct * sp) - y * (st * sp) + z * cp * 16384;
      zo36 = -x * (ct * cp) - y * (st * cp) - z * sp * 16384 + rol * (longint'(1) << 28);
      yo = yo36 >>> 14;
      zo = zo36 >>> 14;
      r = '0;
      r.pen = m;
      if (zo <= 0) begin
         r.behind = 1'b1;
      end else begin
         den = zo * 256;
         nx = 20 * de * xo;
         ny = 20 * de * yo;
         r.sx = 16'(clip16(hw + floor_quot(2 * nx + den, 2 * den)));
         r.sy = 16'(clip16(hh + floor_quot(den - 2 * ny, 2 * den)));
      end
      return r;
   endfunction

   task automatic send_point(logic signed [15:0] x, y, z, logic m, bit typed,
                             pixel_type want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      req_mode <= m;
      do @(posedge clock); while (!req_ready);
      pending_pixels.push_back(project_point(x, y, z, m));
      typed_flags.push_back(typed);
      typed_pixels.push_back(want);
   endtask

   // leaves csr_valid high; the caller drops it after the last beat
   task automatic write_reg(ppp_pkg::csr_index_type idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      view_regs[idx] = (idx >= ppp_pkg::REG_SCREEN_WIDTH) ? (value & 16'h0fff) : value;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
         2: case ($urandom_range(0, 3))
               0: return -16'sd32768;
               1: return 16'sd32767;
               2: return 16'sd0;
               default: return -16'sd1;
            endcase
         default: return $signed(16'($urandom_range(0, 511))) - 16'sd256;
      endcase
   endfunction

   // receiver: mixed stall patterns, plus one long hold-off
   int rx_cycle = 0;
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rx_cycle >= 3000 && rx_cycle < 3300) begin
         rsp_ready <= 1'b0;
      end else begin
         case ((rx_cycle / 97) % 3)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // result beat check
   always @(posedge clock) begin
      pixel_type got, want;
      bit typed;
      pixel_type hand;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_screen_x, rsp_screen_y, rsp_pen_down, rsp_behind_viewer};
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected beat x=%0d y=%0d pen=%0b behind=%0b", $time,
                     got.sx, got.sy, got.pen, got.behind);
            fails++;
         end else begin
            want = pending_pixels.pop_front();
            typed = typed_flags.pop_front();
            hand = typed_pixels.pop_front();
            if (typed && hand !== want) begin
               $display("%0t: table row disagrees with projection", $time);
               fails++;
            end
            if (got !== want) begin
               $display("%0t: expected x=%0d y=%0d pen=%0b behind=%0b,", $time,
                        want.sx, want.sy, want.pen, want.behind,
                        " got x=%0d y=%0d pen=%0b behind=%0b",
                        got.sx, got.sy, got.pen, got.behind);
               fails++;
            end
         end
      end
   end

   point_row_type table_rows [12] = '{
      '{16'sd0,      16'sd0,      16'sd0,      1'b0, 1'b1, '{16'sd320, 16'sd240, 1'b0, 1'b0}},
      '{16'sd0,      16'sd256,    16'sd0,      1'b1, 1'b1, '{16'sd322, 16'sd240, 1'b1, 1'b0}},
      '{16'sd0,      16'sd0,      16'sd256,    1'b0, 1'b1, '{16'sd320, 16'sd238, 1'b0, 1'b0}},
      '{16'sd2560,   16'sd0,      16'sd0,      1'b1, 1'b1, '{16'sd0,   16'sd0,   1'b1, 1'b1}},
      '{16'sd32767,  16'sd5,      -16'sd7,     1'b0, 1'b1, '{16'sd0,   16'sd0,   1'b0, 1'b1}},
      '{16'sd2559,   16'sd32767,  16'sd32767,  1'b1, 1'b0, '0},
      '{-16'sd32768, 16'sd32767,  -16'sd32768, 1'b0, 1'b0, '0},
      '{-16'sd32768, -16'sd32768, 16'sd32767,  1'b1, 1'b0, '0},
      '{16'sd2559,   -16'sd32768, -16'sd32768, 1'b0, 1'b0, '0},
      '{-16'sd1,     -16'sd1,     -16'sd1,     1'b1, 1'b0, '0},
      '{16'sd128,    16'sd128,    -16'sd128,   1'b0, 1'b0, '0},
      '{16'sd2400,   16'sd1000,   -16'sd900,   1'b1, 1'b0, '0}
   };

   logic [15:0] phase_regs [8][8] = '{
      '{16'h4000, 16'h4000, 16'h4000, 16'h4000, 16'hffff, 16'hffff, 16'h0fff, 16'h0fff},
      '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'hffff, 16'h0281, 16'h0001},
      '{16'h7fff, 16'hc000, 16'h0000, 16'hc000, 16'h0001, 16'h0000, 16'h0000, 16'h0000},
      '{16'h0000, 16'h4000, 16'h0000, 16'h4000, 16'h0100, 16'hffff, 16'h0280, 16'h01e0},
      '{16'h2d41, 16'h2d41, 16'hd2bf, 16'h2d41, 16'h1400, 16'h0200, 16'h0320, 16'h0258},
      '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
      '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}
   };

   initial begin
      view_regs = '{ppp_pkg::RST_SIN_THETA, ppp_pkg::RST_COS_THETA,
                    ppp_pkg::RST_SIN_PHI, ppp_pkg::RST_COS_PHI,
                    ppp_pkg::RST_VIEWER_DIST, ppp_pkg::RST_SCREEN_DIST,
                    16'(ppp_pkg::RST_SCREEN_W), 16'(ppp_pkg::RST_SCREEN_H)};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (table_rows[i])
         send_point(table_rows[i].x, table_rows[i].y, table_rows[i].z,
                    table_rows[i].mode, table_rows[i].typed, table_rows[i].want);
      for (int p = 0; p < 8; p++) begin
         drain();
         for (int r = 0; r < 8; r++) begin
            if (p >= 5)
               phase_regs[p][r] = (r < 4)
                  ? 16'($signed(16'($urandom_range(0, 32768))) - 16'sd16384)
                  : 16'($urandom);
            write_reg(ppp_pkg::csr_index_type'(r), phase_regs[p][r]);
         end
         csr_valid <= 1'b0;
         for (int k = 0; k < 235; k++)
            send_point(rand_coord(), rand_coord(), rand_coord(), 1'($urandom), 1'b0, '0);
      end
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fails == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
